>>> hdl/bbaf_pkg.sv
package bbaf_pkg;

  // Operation selector carried in the input tuser.
  localparam logic OP_ENQUEUE = 1'b0;
  localparam logic OP_DEQUEUE = 1'b1;

  // Content operations of a request.
  localparam logic [1:0] CONTENT_CREATE  = 2'd0;
  localparam logic [1:0] CONTENT_REPLACE = 2'd1;

  // Resource status codes.
  localparam logic [1:0] STATUS_CURRENT = 2'd0;
  localparam logic [1:0] STATUS_STALE   = 2'd1;

  // Resource states.
  localparam logic [2:0] RS_RESERVED          = 3'd0;
  localparam logic [2:0] RS_UPLOAD_QUEUED     = 3'd1;
  localparam logic [2:0] RS_GPU_READY         = 3'd2;
  localparam logic [2:0] RS_REPLACEMENT_QUEUED = 3'd3;
  localparam logic [2:0] RS_EVICTING          = 3'd4;
  localparam logic [2:0] RS_RELEASED          = 3'd5;
  localparam logic [2:0] RS_FAILED            = 3'd6;

  // Configuration register indexes.
  localparam logic [1:0] CFG_REQUEST_CAPACITY       = 2'd0;
  localparam logic [1:0] CFG_BYTE_CAPACITY          = 2'd1;
  localparam logic [1:0] CFG_EXPECTED_SCHEMA_ID     = 2'd2;
  localparam logic [1:0] CFG_EXPECTED_SCHEMA_VERSION = 2'd3;

  localparam int S_TDATA_W = 176;
  localparam int M_TDATA_W = 136;

  typedef enum logic [2:0] {
    ENQ_ACCEPTED   = 3'd0,
    ENQ_INVALID    = 3'd1,
    ENQ_STALE      = 3'd2,
    ENQ_CANCELLED  = 3'd3,
    ENQ_FULL_COUNT = 3'd4,
    ENQ_FULL_BYTES = 3'd5
  } enq_code_t;

  typedef enum logic {
    CTL_IDLE,
    CTL_EXEC
  } ctl_state_t;

  typedef struct packed {
    logic        operation;
    logic        request_well_formed;
    logic [31:0] schema_id;
    logic [15:0] schema_version;
    logic [31:0] sequence_req;
    logic [3:0]  resource_kind;
    logic [1:0]  content_op;
    logic [31:0] source_revision;
    logic [31:0] payload_bytes;
    logic [1:0]  status_code;
    logic [2:0]  status_state;
    logic [15:0] request_handle;
  } item_t;

  typedef struct packed {
    logic [31:0] byte_capacity;
    logic [31:0] expected_schema_id;
    logic [15:0] expected_schema_version;
  } admit_cfg_t;

  typedef struct packed {
    enq_code_t  code;
    logic       state_write;
    logic [2:0] new_state;
  } admit_t;

  typedef struct packed {
    logic [15:0] handle;
    logic [31:0] bytes;
  } slot_t;

endpackage

>>> hdl/byte_budget_admission_fifo.sv
// Admission queue for upload requests, bounded by a request count and a byte budget.
//
// Input stream (s_axis): one beat is one item. tuser selects enqueue or dequeue;
// tdata carries the request. Output stream (m_axis): exactly one result beat for
// every input beat, in order. tuser flags that a dequeue returned an entry.
// Configuration channel (cfg_*): a register write per beat, always ready; write
// only while the block is idle.
//
// Timing: an item is taken into an execute register, the slot memory is read at
// the head pointer in the same edge, and the result is committed from execute
// into the output register once that register is free. The block takes no new
// item until the last one has committed, which leaves room for the registered
// read of the slot memory ahead of the commit.
//
// When the receiver stalls, the waiting result holds in the output register, one
// further item is accepted and holds in the execute stage until the output frees.
// Reset empties the queue, clears totals and high-water marks and restores the
// configuration defaults; the slot memory keeps whatever it held.
module byte_budget_admission_fifo #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // request_well_formed, schema_id, schema_version, sequence_req, resource_kind,
  // content_op, source_revision, payload_bytes, status_code, status_state,
  // request_handle, zero fill
  input  logic [bbaf_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // operation
  input  logic [0:0]                     s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // enqueue_code, state_write, new_state, dequeue_handle, dequeue_bytes,
  // retained_count, retained_bytes, count_high_water, bytes_high_water, zero fill
  output logic [bbaf_pkg::M_TDATA_W-1:0] m_axis_tdata,
  // dequeue_valid
  output logic [0:0]                     m_axis_tuser,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [1:0]                     cfg_index,
  input  logic [31:0]                    cfg_data
);

  localparam int AW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW   = $clog2(QUEUE_DEPTH + 1);
  localparam int CMPW = (CW > 5) ? CW : 5;

  bbaf_pkg::ctl_state_t state, state_next;

  logic [4:0]  request_capacity;
  logic [31:0] byte_capacity;
  logic [31:0] expected_schema_id;
  logic [15:0] expected_schema_version;

  logic [AW-1:0] head_index, head_index_next;
  logic [AW-1:0] tail_index, tail_index_next;
  logic [CW-1:0] entry_count, entry_count_next;
  logic [CW-1:0] peak_count, peak_count_next;
  logic [31:0]   held_bytes, held_bytes_next;
  logic [31:0]   peak_bytes, peak_bytes_next;

  bbaf_pkg::item_t      item, item_q;
  bbaf_pkg::admit_cfg_t admit_cfg;
  bbaf_pkg::admit_t     admit;
  bbaf_pkg::slot_t      wr_slot, rd_slot;

  logic            s_beat;
  logic            commit;
  logic            slot_we;
  logic [CMPW-1:0] cap_ext, cap_eff;
  logic            count_full;
  logic            out_valid_next;
  logic            deq_valid;
  logic [15:0]     deq_handle;
  logic [31:0]     deq_bytes;

  assign cfg_ready = 1'b1;

  assign item.operation           = s_axis_tuser[0];
  assign item.request_well_formed = s_axis_tdata[0];
  assign item.schema_id           = s_axis_tdata[32:1];
  assign item.schema_version      = s_axis_tdata[48:33];
  assign item.sequence_req        = s_axis_tdata[80:49];
  assign item.resource_kind       = s_axis_tdata[84:81];
  assign item.content_op          = s_axis_tdata[86:85];
  assign item.source_revision     = s_axis_tdata[118:87];
  assign item.payload_bytes       = s_axis_tdata[150:119];
  assign item.status_code         = s_axis_tdata[152:151];
  assign item.status_state        = s_axis_tdata[155:153];
  assign item.request_handle      = s_axis_tdata[171:156];

  assign s_axis_tready = (state == bbaf_pkg::CTL_IDLE);
  assign s_beat        = s_axis_tvalid && s_axis_tready;
  assign commit        = (state == bbaf_pkg::CTL_EXEC) && (!m_axis_tvalid || m_axis_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      request_capacity        <= 5'd16;
      byte_capacity           <= 32'd1048576;
      expected_schema_id      <= 32'd0;
      expected_schema_version <= 16'd1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        bbaf_pkg::CFG_REQUEST_CAPACITY:        request_capacity <= cfg_data[4:0];
        bbaf_pkg::CFG_BYTE_CAPACITY:           byte_capacity <= cfg_data;
        bbaf_pkg::CFG_EXPECTED_SCHEMA_ID:      expected_schema_id <= cfg_data;
        bbaf_pkg::CFG_EXPECTED_SCHEMA_VERSION: expected_schema_version <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (s_beat) begin
      item_q <= item;
    end
  end

  // A capacity of zero admits one request; anything above the ring depth is clamped.
  assign cap_ext = CMPW'(request_capacity);
  always_comb begin
    cap_eff = cap_ext;
    if (cap_ext == '0) begin
      cap_eff = CMPW'(1);
    end else if (cap_ext > CMPW'(QUEUE_DEPTH)) begin
      cap_eff = CMPW'(QUEUE_DEPTH);
    end
  end
  assign count_full = CMPW'(entry_count) >= cap_eff;

  assign admit_cfg.byte_capacity           = byte_capacity;
  assign admit_cfg.expected_schema_id      = expected_schema_id;
  assign admit_cfg.expected_schema_version = expected_schema_version;

  bbaf_admit u_admit (
    .item       (item_q),
    .cfg        (admit_cfg),
    .count_full (count_full),
    .held_bytes (held_bytes),
    .result     (admit)
  );

  assign wr_slot.handle = item_q.request_handle;
  assign wr_slot.bytes  = item_q.payload_bytes;
  assign slot_we        = commit && (item_q.operation == bbaf_pkg::OP_ENQUEUE) &&
                          (admit.code == bbaf_pkg::ENQ_ACCEPTED);

  // The head entry is read every cycle; head only moves at a commit, so the
  // registered word is current by the time the next item reaches execute.
  bbaf_slot_ram #(
    .DEPTH (QUEUE_DEPTH),
    .AW    (AW)
  ) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (tail_index),
    .wdata (wr_slot),
    .raddr (head_index),
    .rdata (rd_slot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bbaf_pkg::CTL_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next       = state;
    head_index_next  = head_index;
    tail_index_next  = tail_index;
    entry_count_next = entry_count;
    held_bytes_next  = held_bytes;
    peak_count_next  = peak_count;
    peak_bytes_next  = peak_bytes;
    deq_valid        = 1'b0;
    deq_handle       = 16'd0;
    deq_bytes        = 32'd0;
    out_valid_next   = m_axis_tvalid && !m_axis_tready;
    unique case (state)
      bbaf_pkg::CTL_IDLE: begin
        if (s_beat) begin
          state_next = bbaf_pkg::CTL_EXEC;
        end
      end
      bbaf_pkg::CTL_EXEC: begin
        if (commit) begin
          state_next     = bbaf_pkg::CTL_IDLE;
          out_valid_next = 1'b1;
          if (item_q.operation == bbaf_pkg::OP_ENQUEUE) begin
            if (admit.code == bbaf_pkg::ENQ_ACCEPTED) begin
              tail_index_next  = (tail_index == AW'(QUEUE_DEPTH - 1)) ? '0 : tail_index + 1'b1;
              entry_count_next = entry_count + 1'b1;
              held_bytes_next  = held_bytes + item_q.payload_bytes;
              if (entry_count_next > peak_count) begin
                peak_count_next = entry_count_next;
              end
              if (held_bytes_next > peak_bytes) begin
                peak_bytes_next = held_bytes_next;
              end
            end
          end else if (entry_count != '0) begin
            deq_valid        = 1'b1;
            deq_handle       = rd_slot.handle;
            deq_bytes        = rd_slot.bytes;
            head_index_next  = (head_index == AW'(QUEUE_DEPTH - 1)) ? '0 : head_index + 1'b1;
            entry_count_next = entry_count - 1'b1;
            held_bytes_next  = held_bytes - rd_slot.bytes;
          end
        end
      end
      default: state_next = bbaf_pkg::CTL_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_index    <= '0;
      tail_index    <= '0;
      entry_count   <= '0;
      held_bytes    <= 32'd0;
      peak_count    <= '0;
      peak_bytes    <= 32'd0;
      m_axis_tvalid <= 1'b0;
    end else begin
      head_index    <= head_index_next;
      tail_index    <= tail_index_next;
      entry_count   <= entry_count_next;
      held_bytes    <= held_bytes_next;
      peak_count    <= peak_count_next;
      peak_bytes    <= peak_bytes_next;
      m_axis_tvalid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      m_axis_tuser[0]       <= deq_valid;
      m_axis_tdata[135:129] <= 7'd0;
      m_axis_tdata[128:97]  <= peak_bytes_next;
      m_axis_tdata[96:92]   <= 5'(peak_count_next);
      m_axis_tdata[91:60]   <= held_bytes_next;
      m_axis_tdata[59:55]   <= 5'(entry_count_next);
      m_axis_tdata[54:23]   <= deq_bytes;
      m_axis_tdata[22:7]    <= deq_handle;
      if (item_q.operation == bbaf_pkg::OP_ENQUEUE) begin
        m_axis_tdata[6:4] <= admit.new_state;
        m_axis_tdata[3]   <= admit.state_write;
        m_axis_tdata[2:0] <= admit.code;
      end else begin
        m_axis_tdata[6:4] <= bbaf_pkg::RS_RESERVED;
        m_axis_tdata[3]   <= 1'b0;
        m_axis_tdata[2:0] <= bbaf_pkg::ENQ_ACCEPTED;
      end
    end
  end

endmodule

>>> hdl/bbaf_slot_ram.sv
module bbaf_slot_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  bbaf_pkg::slot_t wdata,
  input  logic [AW-1:0]   raddr,
  output bbaf_pkg::slot_t rdata
);

  bbaf_pkg::slot_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

>>> hdl/bbaf_admit.sv
module bbaf_admit (
  input  bbaf_pkg::item_t     item,
  input  bbaf_pkg::admit_cfg_t cfg,
  input  logic                count_full,
  input  logic [31:0]         held_bytes,
  output bbaf_pkg::admit_t    result
);

  logic        replace;
  logic        op_known;
  logic        well_formed;
  logic [2:0]  expected_state;
  logic        byte_over;
  logic [32:0] byte_sum;

  assign replace  = (item.content_op == bbaf_pkg::CONTENT_REPLACE);
  assign op_known = (item.content_op == bbaf_pkg::CONTENT_CREATE) || replace;

  assign well_formed = item.request_well_formed &&
                       (item.schema_id == cfg.expected_schema_id) &&
                       (item.schema_version == cfg.expected_schema_version) &&
                       (item.sequence_req != 32'd0) &&
                       (item.resource_kind != 4'd0) &&
                       op_known &&
                       (!replace || (item.source_revision != 32'd0));

  assign expected_state = replace ? bbaf_pkg::RS_GPU_READY : bbaf_pkg::RS_RESERVED;

  // The sum is kept one bit wider so that a budget near the top cannot wrap.
  assign byte_sum  = {1'b0, held_bytes} + {1'b0, item.payload_bytes};
  assign byte_over = byte_sum > {1'b0, cfg.byte_capacity};

  always_comb begin
    result.code        = bbaf_pkg::ENQ_ACCEPTED;
    result.state_write = 1'b0;
    result.new_state   = bbaf_pkg::RS_RESERVED;
    if (!well_formed) begin
      result.code = bbaf_pkg::ENQ_INVALID;
    end else if ((item.status_code != bbaf_pkg::STATUS_CURRENT) ||
                 (item.status_state != expected_state)) begin
      if (item.status_code == bbaf_pkg::STATUS_STALE) begin
        result.code = bbaf_pkg::ENQ_STALE;
      end else if (item.status_code != bbaf_pkg::STATUS_CURRENT) begin
        result.code = bbaf_pkg::ENQ_INVALID;
      end else begin
        case (item.status_state) inside
          bbaf_pkg::RS_EVICTING, bbaf_pkg::RS_RELEASED, bbaf_pkg::RS_FAILED: begin
            result.code = bbaf_pkg::ENQ_CANCELLED;
          end
          default: begin
            result.code = bbaf_pkg::ENQ_INVALID;
          end
        endcase
      end
    end else if (count_full) begin
      result.code = bbaf_pkg::ENQ_FULL_COUNT;
    end else if (byte_over) begin
      result.code = bbaf_pkg::ENQ_FULL_BYTES;
    end else begin
      result.state_write = 1'b1;
      result.new_state   = replace ? bbaf_pkg::RS_REPLACEMENT_QUEUED
                                   : bbaf_pkg::RS_UPLOAD_QUEUED;
    end
  end

endmodule

>>> hdl/bbaf_checker.sv
module bbaf_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_axis_tvalid,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [bbaf_pkg::M_TDATA_W-1:0] m_axis_tdata,
  input logic [0:0]                     m_axis_tuser
);

  // A held result beat keeps its contents.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // Each item is executed before another is taken.
  assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input accepted while an item is in execute");

  // A rejected request never asks for a status write-back.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tdata[2:0] != bbaf_pkg::ENQ_ACCEPTED) |-> !m_axis_tdata[3] &&
      (m_axis_tdata[6:4] == bbaf_pkg::RS_RESERVED))
    else $error("status write-back on a rejected request");

  // A returned entry carries no enqueue verdict.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |->
      (m_axis_tdata[2:0] == bbaf_pkg::ENQ_ACCEPTED) && !m_axis_tdata[3])
    else $error("dequeue result carries enqueue fields");

  // The byte total never exceeds its high-water mark.
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[91:60] <= m_axis_tdata[128:97])
    else $error("retained bytes above high-water mark");

endmodule

bind byte_budget_admission_fifo bbaf_checker u_bbaf_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
